// ----- src/socf_pkg.sv -----
// shared types, microcode format and the microcode program of the complementary filter
`default_nettype none

package socf_pkg;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ERR,
    OP_AP,
    OP_G,
    OP_INT,
    OP_SUM,
    OP_EST,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    A_E,
    A_A,
    A_T,
    A_Q,
    A_RATE
  } asel_e;

  typedef enum logic [1:0] {
    B_K,
    B_GG,
    B_DT
  } bsel_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_AXIS,
    J_END
  } jmp_e;

  typedef struct packed {
    op_e   op;
    logic  mul_en;
    asel_e asel;
    bsel_e bsel;
    jmp_e  jmp;
  } ctrl_t;

  typedef struct packed {
    logic  run;
    logic  ax;
    ctrl_t cw;
  } uop_t;

  typedef struct packed {
    logic        [15:0] k;
    logic        [15:0] dt;
    logic signed [15:0] gg;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
  } in_t;

  localparam int unsigned PcWidth = 4;
  localparam int unsigned AddrWidth = 4;

  localparam logic [1:0] RegTimeConstant = 2'd0;
  localparam logic [1:0] RegSamplePeriod = 2'd1;
  localparam logic [1:0] RegGyroGain = 2'd2;

  localparam logic [15:0] TimeConstantRst = 16'd256;
  localparam logic [15:0] SamplePeriodRst = 16'd655;
  localparam logic [15:0] GyroGainRst = 16'd256;

  localparam ctrl_t CwIdle = '{op: OP_NOP, mul_en: 1'b0, asel: A_E, bsel: B_K, jmp: J_END};

  // one axis runs steps 0..8, step 8 loops back once for the second axis
  function automatic ctrl_t ucode(input logic [PcWidth-1:0] pc);
    ctrl_t cw;
    cw = CwIdle;
    case (pc)
      4'd0: cw = '{op: OP_ERR, mul_en: 1'b0, asel: A_E,    bsel: B_K,  jmp: J_NEXT};
      4'd1: cw = '{op: OP_NOP, mul_en: 1'b1, asel: A_E,    bsel: B_K,  jmp: J_NEXT};
      4'd2: cw = '{op: OP_AP,  mul_en: 1'b1, asel: A_RATE, bsel: B_GG, jmp: J_NEXT};
      4'd3: cw = '{op: OP_G,   mul_en: 1'b1, asel: A_A,    bsel: B_K,  jmp: J_NEXT};
      4'd4: cw = '{op: OP_NOP, mul_en: 1'b1, asel: A_Q,    bsel: B_DT, jmp: J_NEXT};
      4'd5: cw = '{op: OP_INT, mul_en: 1'b0, asel: A_E,    bsel: B_K,  jmp: J_NEXT};
      4'd6: cw = '{op: OP_SUM, mul_en: 1'b0, asel: A_E,    bsel: B_K,  jmp: J_NEXT};
      4'd7: cw = '{op: OP_NOP, mul_en: 1'b1, asel: A_T,    bsel: B_DT, jmp: J_NEXT};
      4'd8: cw = '{op: OP_EST, mul_en: 1'b0, asel: A_E,    bsel: B_K,  jmp: J_AXIS};
      4'd9: cw = '{op: OP_OUT, mul_en: 1'b0, asel: A_E,    bsel: B_K,  jmp: J_END};
      default: cw = CwIdle;
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ----- src/socf_regs.sv -----
// configuration register file behind the apb-style port
`default_nettype none

module socf_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [socf_pkg::AddrWidth-1:0]     paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  output socf_pkg::cfg_t                          cfg_o
);

  logic [15:0] k_q, dt_q, gg_q;
  logic [1:0]  idx;
  logic        wr;

  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= socf_pkg::TimeConstantRst;
      dt_q <= socf_pkg::SamplePeriodRst;
      gg_q <= socf_pkg::GyroGainRst;
    end else if (wr) begin
      case (idx)
        socf_pkg::RegTimeConstant: k_q  <= pwdata[15:0];
        socf_pkg::RegSamplePeriod: dt_q <= pwdata[15:0];
        socf_pkg::RegGyroGain:     gg_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      socf_pkg::RegTimeConstant: prdata = {16'h0000, k_q};
      socf_pkg::RegSamplePeriod: prdata = {16'h0000, dt_q};
      socf_pkg::RegGyroGain:     prdata = {16'h0000, gg_q};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.k  = k_q;
  assign cfg_o.dt = dt_q;
  assign cfg_o.gg = gg_q;

endmodule

`default_nettype wire

// ----- src/socf_seq.sv -----
// microcode sequencer: step counter, axis bit and jump handling
`default_nettype none

module socf_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           stall_i,
  output socf_pkg::uop_t      uop_o
);

  logic                            run_q, run_d;
  logic                            ax_q, ax_d;
  logic [socf_pkg::PcWidth-1:0]    pc_q, pc_d;
  socf_pkg::ctrl_t                 cw;

  assign cw = run_q ? socf_pkg::ucode(pc_q) : socf_pkg::CwIdle;

  always_comb begin
    run_d = run_q;
    ax_d  = ax_q;
    pc_d  = pc_q;
    if (!run_q) begin
      if (start_i) begin
        run_d = 1'b1;
        ax_d  = 1'b0;
        pc_d  = '0;
      end
    end else if (!stall_i) begin
      case (cw.jmp)
        socf_pkg::J_NEXT: pc_d = pc_q + 1'b1;
        socf_pkg::J_AXIS: begin
          if (!ax_q) begin
            ax_d = 1'b1;
            pc_d = '0;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
        socf_pkg::J_END: run_d = 1'b0;
        default:         run_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      ax_q  <= 1'b0;
      pc_q  <= '0;
    end else begin
      run_q <= run_d;
      ax_q  <= ax_d;
      pc_q  <= pc_d;
    end
  end

  assign uop_o.run = run_q;
  assign uop_o.ax  = ax_q;
  assign uop_o.cw  = cw;

endmodule

`default_nettype wire

// ----- src/socf_dp.sv -----
// filter datapath: one shared multiplier, saturating adder and the filter state
`default_nettype none

module socf_dp #(
  parameter int unsigned W = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire socf_pkg::uop_t       uop_i,
  input  wire socf_pkg::cfg_t       cfg_i,
  input  wire socf_pkg::in_t        in_i,
  output logic signed [15:0]        angle_x_o,
  output logic signed [15:0]        angle_y_o
);

  localparam int unsigned PW = W + 17;

  function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi, lo;
    hi = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[W-1:0];
    if (v < lo) return lo[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [W-1:0] v);
    logic signed [W-1:0] s, hi, lo;
    s  = v >>> 8;
    hi = {{(W-15){1'b0}}, {15{1'b1}}};
    lo = ~hi;
    if (s > hi) return 16'sh7fff;
    if (s < lo) return -16'sh8000;
    return s[15:0];
  endfunction

  logic signed [W-1:0]  est_x_q, est_y_q, int_x_q, int_y_q;
  logic signed [W-1:0]  e_q, a_q, p_q, g_q, t_q;
  logic signed [W-1:0]  e_d, a_d, p_d, g_d, t_d;
  logic signed [W-1:0]  est_sel, int_sel, est_new, int_new;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [W-1:0]  mul_a;
  logic signed [16:0]   mul_b;
  logic signed [15:0]   accel_sel, rate_sel;
  logic signed [PW-1:0] accel_w;

  assign est_sel   = uop_i.ax ? est_y_q : est_x_q;
  assign int_sel   = uop_i.ax ? int_y_q : int_x_q;
  assign accel_sel = uop_i.ax ? in_i.accel_y : in_i.accel_x;
  assign rate_sel  = uop_i.ax ? in_i.rate_y : in_i.rate_x;
  assign accel_w   = PW'(signed'({accel_sel, 8'h00}));

  // operand select
  always_comb begin
    case (uop_i.cw.asel)
      socf_pkg::A_E:    mul_a = e_q;
      socf_pkg::A_A:    mul_a = a_q;
      socf_pkg::A_T:    mul_a = t_q;
      socf_pkg::A_Q:    mul_a = sat_w(prod_q >>> 8);
      socf_pkg::A_RATE: mul_a = W'(rate_sel);
      default:          mul_a = '0;
    endcase
    case (uop_i.cw.bsel)
      socf_pkg::B_K:  mul_b = signed'({1'b0, cfg_i.k});
      socf_pkg::B_GG: mul_b = {cfg_i.gg[15], cfg_i.gg};
      socf_pkg::B_DT: mul_b = signed'({1'b0, cfg_i.dt});
      default:        mul_b = '0;
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    e_d     = e_q;
    a_d     = a_q;
    p_d     = p_q;
    g_d     = g_q;
    t_d     = t_q;
    est_new = est_sel;
    int_new = int_sel;
    case (uop_i.cw.op)
      socf_pkg::OP_ERR: e_d = sat_w(accel_w - PW'(est_sel));
      socf_pkg::OP_AP: begin
        a_d = sat_w(prod_q >>> 8);
        p_d = sat_w(prod_q >>> 7);
      end
      socf_pkg::OP_G:   g_d = sat_w(prod_q);
      socf_pkg::OP_INT: int_new = sat_w(PW'(int_sel) + (prod_q >>> 16));
      socf_pkg::OP_SUM: t_d = sat_w(PW'(int_sel) + PW'(p_q) + PW'(g_q));
      socf_pkg::OP_EST: est_new = sat_w(PW'(est_sel) + (prod_q >>> 16));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
    a_q <= a_d;
    p_q <= p_d;
    g_q <= g_d;
    t_q <= t_d;
    if (uop_i.cw.mul_en) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_x_q <= '0;
      est_y_q <= '0;
      int_x_q <= '0;
      int_y_q <= '0;
    end else begin
      if (uop_i.cw.op == socf_pkg::OP_INT) begin
        if (uop_i.ax) int_y_q <= int_new;
        else          int_x_q <= int_new;
      end
      if (uop_i.cw.op == socf_pkg::OP_EST) begin
        if (uop_i.ax) est_y_q <= est_new;
        else          est_x_q <= est_new;
      end
    end
  end

  assign angle_x_o = sat16(est_x_q);
  assign angle_y_o = sat16(est_y_q);

endmodule

`default_nettype wire

// ----- src/second_order_complementary_filter.sv -----
// Two-axis second-order complementary filter, top level.
// Input stream: one transfer carries both accelerometer tilt angles and both
// gyro rates (Q8.8). Output stream: one transfer per input with the two new
// angle estimates (Q8.8, saturated). Gains and step time are set over the
// apb-style port; the user must set them only while the block is idle, the
// block does not enforce this. Reads return the stored values. A microcoded
// sequencer steps a single shared multiplier and a saturating adder through
// nine steps per axis plus one output step. The next item is taken only once
// the last result is loaded, as all products share the one multiplier port.
// The input is taken while a result still waits in the output register;
// if the receiver stalls, the sequencer holds at its output step until the
// register frees up, and no input is taken meanwhile.
// Reset clears both estimates and integrators and loads the default
// gains; the first item can be sent in the cycle after reset is released.
`default_nettype none

module second_order_complementary_filter #(
  parameter int unsigned STATE_WIDTH = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // accel_angle_x, accel_angle_y, gyro_rate_x, gyro_rate_y
  input  wire logic [63:0]                        s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // angle_x, angle_y
  output logic [31:0]                             m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [socf_pkg::AddrWidth-1:0]     paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  socf_pkg::cfg_t     cfg;
  socf_pkg::uop_t     uop;
  socf_pkg::in_t      in_q;
  logic               in_xfer, stall, out_load;
  logic               out_valid_q;
  logic [31:0]        out_data_q;
  logic signed [15:0] angle_x, angle_y;

  assign s_axis_tready = ~uop.run;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign stall         = (uop.cw.op == socf_pkg::OP_OUT) & out_valid_q & ~m_axis_tready;
  assign out_load      = (uop.cw.op == socf_pkg::OP_OUT) & ~stall;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.accel_x <= s_axis_tdata[15:0];
      in_q.accel_y <= s_axis_tdata[31:16];
      in_q.rate_x  <= s_axis_tdata[47:32];
      in_q.rate_y  <= s_axis_tdata[63:48];
    end
    if (out_load) begin
      out_data_q <= {angle_y, angle_x};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  socf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  socf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .stall_i (stall),
    .uop_o   (uop)
  );

  socf_dp #(
    .W (STATE_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .uop_i     (uop),
    .cfg_i     (cfg),
    .in_i      (in_q),
    .angle_x_o (angle_x),
    .angle_y_o (angle_y)
  );

endmodule

`default_nettype wire
